// File: src/urx_pkg.sv
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants for the uart receive ring with sticky errors.
// ----------------------------------------------------------------------------
package urx_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned LEN_W         = 8;
  localparam int unsigned BW_W          = 6;

  typedef enum logic [1:0] {
    MODE_RX    = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_BAD_LEN = 3'd1,
    STAT_SHORT   = 3'd2,
    STAT_OVERRUN = 3'd3,
    STAT_FRAMING = 3'd4,
    STAT_PARITY  = 3'd5
  } status_e;

  // bit positions in the sticky error latch
  localparam int unsigned ERR_OVR = 0;
  localparam int unsigned ERR_FRM = 1;
  localparam int unsigned ERR_PAR = 2;
  localparam int unsigned ERR_W   = 3;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              data_valid;
    status_e           status;
    logic [BW_W-1:0]   bytes_waiting;
    logic              last;
  } result_t;

endpackage

// File: src/uart_rx_ring_with_sticky_errors.sv
// ----------------------------------------------------------------------------
// uart_rx_ring_with_sticky_errors
// Receive ring buffer with sticky overrun, framing and parity flags.
// ----------------------------------------------------------------------------
// A receive event, a clear or an unused mode gives one result. A read of N
// bytes, once checked, fetches and then pops each byte in turn (the ring
// store has a registered read port, so each pop waits for the next byte to
// be fetched) and ends with a status result that reports the highest-priority
// latched error (overrun, then framing, then parity) and clears all of them:
// N + 1 results. The input is not ready while a read is in progress. The
// ring holds at most DEPTH-1 bytes; a byte arriving at a full ring is dropped
// and overrun latches. No clearing pass after reset: only bytes between the
// pointers are ever read.
module uart_rx_ring_with_sticky_errors #(
  parameter int unsigned DEPTH = urx_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [urx_pkg::DATA_W-1:0] rx_byte_i,
  input  logic                       rx_has_byte_i,
  input  logic                       line_overrun_i,
  input  logic                       line_framing_i,
  input  logic                       line_parity_i,
  input  logic [urx_pkg::LEN_W-1:0]  read_length_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [urx_pkg::DATA_W-1:0] data_out_o,
  output logic                       data_valid_o,
  output logic [2:0]                 status_o,
  output logic [urx_pkg::BW_W-1:0]   bytes_waiting_o,
  output logic                       last_o
);
  import urx_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE,
    S_STATUS
  } state_e;

  state_e             state_q;
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, level_q, rem_q;
  logic [ERR_W-1:0]   err_q;
  logic               fetched_q;
  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               load;

  logic               in_fire, out_free, full, push, pop;
  logic               len_bad, len_short;
  logic [DATA_W-1:0]  rdata;
  status_e            err_status;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (level_q == PTR_W'(DEPTH - 1));
  assign push       = in_fire && (mode_i == MODE_RX) && rx_has_byte_i && !full;
  assign pop        = (state_q == S_BYTE) && fetched_q && out_free;
  assign len_bad    = read_length_i > LEN_W'(DEPTH);
  assign len_short  = LEN_W'(level_q) < read_length_i;

  always_comb begin
    if (err_q[ERR_OVR]) begin
      err_status = STAT_OVERRUN;
    end else if (err_q[ERR_FRM]) begin
      err_status = STAT_FRAMING;
    end else if (err_q[ERR_PAR]) begin
      err_status = STAT_PARITY;
    end else begin
      err_status = STAT_OK;
    end
  end

  urx_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (rx_byte_i),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // result to load into the output register
  always_comb begin
    load                = 1'b0;
    res_d.data          = '0;
    res_d.data_valid    = 1'b0;
    res_d.status        = STAT_OK;
    res_d.bytes_waiting = BW_W'(level_q);
    res_d.last          = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_i)
            MODE_RX: begin
              load                = 1'b1;
              res_d.bytes_waiting = push ? BW_W'(level_q + 1'b1) : BW_W'(level_q);
            end
            MODE_READ: begin
              if (len_bad) begin
                load         = 1'b1;
                res_d.status = STAT_BAD_LEN;
              end else if (len_short) begin
                load         = 1'b1;
                res_d.status = STAT_SHORT;
              end
            end
            MODE_CLEAR: begin
              load                = 1'b1;
              res_d.bytes_waiting = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_BYTE: begin
        if (pop) begin
          load                = 1'b1;
          res_d.data          = rdata;
          res_d.data_valid    = 1'b1;
          res_d.bytes_waiting = BW_W'(level_q - 1'b1);
          res_d.last          = 1'b0;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          load         = 1'b1;
          res_d.status = err_status;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      level_q     <= '0;
      rem_q       <= '0;
      err_q       <= '0;
      fetched_q   <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        res_q <= res_d;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (mode_i)
              MODE_RX: begin
                err_q[ERR_OVR] <= err_q[ERR_OVR] | line_overrun_i | (rx_has_byte_i & full);
                err_q[ERR_FRM] <= err_q[ERR_FRM] | line_framing_i;
                err_q[ERR_PAR] <= err_q[ERR_PAR] | line_parity_i;
                if (push) begin
                  wr_ptr_q <= ptr_inc(wr_ptr_q);
                  level_q  <= PTR_W'(level_q + 1'b1);
                end
              end
              MODE_READ: begin
                if (!len_bad && !len_short) begin
                  rem_q     <= read_length_i[PTR_W-1:0];
                  fetched_q <= 1'b0;
                  state_q   <= (read_length_i == '0) ? S_STATUS : S_BYTE;
                end
              end
              MODE_CLEAR: begin
                rd_ptr_q <= wr_ptr_q;
                level_q  <= '0;
                err_q    <= '0;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_BYTE: begin
          if (pop) begin
            rd_ptr_q  <= ptr_inc(rd_ptr_q);
            level_q   <= PTR_W'(level_q - 1'b1);
            rem_q     <= PTR_W'(rem_q - 1'b1);
            fetched_q <= 1'b0;
            if (rem_q == PTR_W'(1)) begin
              state_q <= S_STATUS;
            end
          end else begin
            // the read port registers the byte at the read address; mark it fetched
            fetched_q <= 1'b1;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            err_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = res_q.data;
  assign data_valid_o    = res_q.data_valid;
  assign status_o        = res_q.status;
  assign bytes_waiting_o = res_q.bytes_waiting;
  assign last_o          = res_q.last;

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= PTR_W'(DEPTH - 1))
    else $error("ring level above capacity");

  a_rem_covered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE) |-> (rem_q != '0) && (rem_q <= level_q))
    else $error("read in progress without enough bytes in ring");

  a_byte_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_valid_o) |-> (status_o == STAT_OK) && !last_o)
    else $error("byte item carries status or last");

  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STATUS && out_free) |=> (err_q == '0) && (state_q == S_IDLE))
    else $error("status item did not clear error latch");
`endif

endmodule

// File: src/urx_ram.sv
// ----------------------------------------------------------------------------
// urx_ram
// Byte store of the receive ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module urx_ram #(
  parameter int unsigned DEPTH  = urx_pkg::DEPTH_DEFAULT,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [urx_pkg::DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [urx_pkg::DATA_W-1:0] rdata_o
);
  import urx_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
